>>> hdl/triangle_face_normal_defines.svh
// ----------------------------------------------------------------------------
// triangle_face_normal_defines.svh
// Assertion macros for the checker file of the face normal block.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("face normal check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("face normal check failed");

`endif

>>> hdl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants and types of the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int NORMAL_FRAC_DEF = 14;

    localparam int NORM_WIDTH = 16;   // output component width
    localparam int MAG_BITS   = 30;   // normalized magnitude, top bit at 29
    localparam int SUM_BITS   = 62;   // sum of three squared magnitudes
    localparam int ROOT_BITS  = 31;   // floor(sqrt(sum))
    localparam int REM_BITS   = 34;   // square root partial remainder

    localparam logic [1:0] BEAT_LAST = 2'd2;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } flags_t;

endpackage

>>> hdl/tfn_norm_cell.sv
// ----------------------------------------------------------------------------
// tfn_norm_cell
// One step of the leading-one normalizer: shifts all three magnitudes left
// by SH when the top SH bits of their OR are clear.
// ----------------------------------------------------------------------------
module tfn_norm_cell #(
    parameter int W  = 34,
    parameter int SH = 1,
    parameter int SW = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [SW-1:0]       in_side,
    input  logic [2:0][W-1:0]   in_mag,
    output logic                out_valid,
    output logic [SW-1:0]       out_side,
    output logic [2:0][W-1:0]   out_mag
);

    logic               vld_reg;
    logic [SW-1:0]      side_reg;
    logic [2:0][W-1:0]  mag_reg;
    logic [2:0][W-1:0]  mag_next;
    logic [W-1:0]       orv;

    always_comb begin
        orv = in_mag[0] | in_mag[1] | in_mag[2];
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = (orv[W-1 -: SH] == '0) ? (in_mag[i] << SH) : in_mag[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= in_side;
            mag_reg  <= mag_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_side  = side_reg;
    assign out_mag   = mag_reg;

endmodule

>>> hdl/tfn_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tfn_sqrt_cell
// One digit of a restoring integer square root: retires one root bit,
// consuming two radicand bits.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell import tfn_pkg::*; #(
    parameter int SW = 94
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [SW-1:0]         in_side,
    input  logic [SUM_BITS-1:0]   in_s,
    input  logic [REM_BITS-1:0]   in_r,
    input  logic [ROOT_BITS-1:0]  in_q,
    output logic                  out_valid,
    output logic [SW-1:0]         out_side,
    output logic [SUM_BITS-1:0]   out_s,
    output logic [REM_BITS-1:0]   out_r,
    output logic [ROOT_BITS-1:0]  out_q
);

    logic                 vld_reg;
    logic [SW-1:0]        side_reg;
    logic [SUM_BITS-1:0]  s_reg;
    logic [REM_BITS-1:0]  r_reg, r_next, r2, trial;
    logic [ROOT_BITS-1:0] q_reg, q_next;
    logic                 ge;

    always_comb begin
        r2     = {in_r[REM_BITS-3:0], in_s[SUM_BITS-1 -: 2]};
        trial  = {{(REM_BITS-ROOT_BITS-2){1'b0}}, in_q, 2'b01};
        ge     = (r2 >= trial);
        r_next = ge ? (r2 - trial) : r2;
        q_next = {in_q[ROOT_BITS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= in_side;
            s_reg    <= {in_s[SUM_BITS-3:0], 2'b00};
            r_reg    <= r_next;
            q_reg    <= q_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_side  = side_reg;
    assign out_s     = s_reg;
    assign out_r     = r_reg;
    assign out_q     = q_reg;

endmodule

>>> hdl/tfn_div_cell.sv
// ----------------------------------------------------------------------------
// tfn_div_cell
// One quotient bit of three restoring divisions sharing one divisor.
// Dividend bits leave the top of nq while quotient bits enter the bottom.
// ----------------------------------------------------------------------------
module tfn_div_cell import tfn_pkg::*; #(
    parameter int QW = 15,
    parameter int SW = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [SW-1:0]                in_side,
    input  logic [ROOT_BITS-1:0]         in_div,
    input  logic [2:0][ROOT_BITS-1:0]    in_rem,
    input  logic [2:0][QW-1:0]           in_nq,
    output logic                         out_valid,
    output logic [SW-1:0]                out_side,
    output logic [ROOT_BITS-1:0]         out_div,
    output logic [2:0][ROOT_BITS-1:0]    out_rem,
    output logic [2:0][QW-1:0]           out_nq
);

    logic                        vld_reg;
    logic [SW-1:0]               side_reg;
    logic [ROOT_BITS-1:0]        div_reg;
    logic [2:0][ROOT_BITS-1:0]   rem_reg, rem_next;
    logic [2:0][QW-1:0]          nq_reg, nq_next;
    logic [ROOT_BITS:0]          r2   [3];
    logic [ROOT_BITS:0]          diff [3];
    logic [2:0]                  ge;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            r2[i]       = {in_rem[i], in_nq[i][QW-1]};
            ge[i]       = (r2[i] >= {1'b0, in_div});
            diff[i]     = r2[i] - {1'b0, in_div};
            rem_next[i] = ge[i] ? diff[i][ROOT_BITS-1:0] : r2[i][ROOT_BITS-1:0];
            nq_next[i]  = {in_nq[i][QW-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= in_side;
            div_reg  <= in_div;
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_side  = side_reg;
    assign out_div   = div_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;

endmodule

>>> hdl/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a fixed point triangle, cross product of its edges
// normalized to signed Q1.14, emitted once per vertex.
// ----------------------------------------------------------------------------
//  channel | direction | payload                         | handshake
//  s_      | in        | s_ax..s_cz, three vertices      | s_valid / s_ready
//  m_      | out       | m_nx m_ny m_nz m_degenerate     | m_valid / m_ready
//          |           | m_last on third copy            |
//
//  The output port sends three copies of each normal, one per cycle while
//  m_ready is high, and the chain advances as a whole while the output
//  register is free or emptying on its last copy, or while its tail is empty.
//  Stage order: edges, products, cross, normalize, square, sum, root, divide.
//  aresetn is synchronous, active low, and clears all valid bits.
//  A stalled m_ side freezes the whole chain while its tail holds a
//  result; with an empty tail the chain still moves up.
// ----------------------------------------------------------------------------
module triangle_face_normal import tfn_pkg::*; #(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_ax,
    input  logic signed [COORD_WIDTH-1:0] s_ay,
    input  logic signed [COORD_WIDTH-1:0] s_az,
    input  logic signed [COORD_WIDTH-1:0] s_bx,
    input  logic signed [COORD_WIDTH-1:0] s_by,
    input  logic signed [COORD_WIDTH-1:0] s_bz,
    input  logic signed [COORD_WIDTH-1:0] s_cx,
    input  logic signed [COORD_WIDTH-1:0] s_cy,
    input  logic signed [COORD_WIDTH-1:0] s_cz,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [NORM_WIDTH-1:0] m_nx,
    output logic signed [NORM_WIDTH-1:0] m_ny,
    output logic signed [NORM_WIDTH-1:0] m_nz,
    output logic                         m_degenerate,
    output logic                         m_last
);

    // Edge width: coordinates wider than 30 bits get their edges truncated.
    localparam int EW     = (COORD_WIDTH > 30) ? 32 : COORD_WIDTH + 1;
    localparam int RED_SH = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
    localparam int MW     = 2 * EW;                        // cross magnitude
    localparam int NW     = (MW > MAG_BITS) ? MW : MAG_BITS; // normalizer field
    localparam int NSTG   = $clog2(NW);
    localparam int QW     = NORMAL_FRAC_BITS + 1;          // quotient bits
    localparam int NNW    = MAG_BITS + QW;                 // rounded dividend
    localparam int QX     = (QW > NORM_WIDTH) ? QW : NORM_WIDTH;
    localparam int FW     = $bits(flags_t);
    localparam int SQW    = FW + 3 * MAG_BITS;

    // ---------------- chain control ----------------
    logic       adv;
    logic       tail_valid;
    logic       hold_vld_reg;
    logic [1:0] beat_reg;
    logic       hold_free;

    // output register frees when empty or when its last copy leaves
    assign hold_free = !hold_vld_reg || (m_ready && (beat_reg == BEAT_LAST));
    assign adv       = hold_free || !tail_valid;
    assign s_ready   = adv;

    // ---------------- stage 1: edges ----------------
    function automatic logic signed [EW-1:0] reduce_edge(
        input logic signed [COORD_WIDTH:0] d
    );
        logic [COORD_WIDTH:0] a;
        logic [COORD_WIDTH:0] sh;
        a  = d[COORD_WIDTH] ? (-d) : d;
        sh = a >> RED_SH;
        return d[COORD_WIDTH] ? (-sh[EW-1:0]) : sh[EW-1:0];
    endfunction

    logic signed [COORD_WIDTH-1:0] crd [9];
    logic signed [COORD_WIDTH:0]   d1 [3];
    logic signed [COORD_WIDTH:0]   d2 [3];
    logic signed [EW-1:0]          e1_reg [3];
    logic signed [EW-1:0]          e2_reg [3];
    logic                          v_e_reg;

    assign crd[0] = s_ax;
    assign crd[1] = s_ay;
    assign crd[2] = s_az;
    assign crd[3] = s_bx;
    assign crd[4] = s_by;
    assign crd[5] = s_bz;
    assign crd[6] = s_cx;
    assign crd[7] = s_cy;
    assign crd[8] = s_cz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d1[i] = {crd[3+i][COORD_WIDTH-1], crd[3+i]} - {crd[i][COORD_WIDTH-1], crd[i]};
            d2[i] = {crd[6+i][COORD_WIDTH-1], crd[6+i]} - {crd[i][COORD_WIDTH-1], crd[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= reduce_edge(d1[i]);
                e2_reg[i] <= reduce_edge(d2[i]);
            end
        end
    end

    // ---------------- stage 2: six products ----------------
    logic signed [MW-1:0] pa_reg [3];
    logic signed [MW-1:0] pb_reg [3];
    logic                 v_p_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_reg[0] <= MW'(e1_reg[1] * e2_reg[2]);
            pb_reg[0] <= MW'(e1_reg[2] * e2_reg[1]);
            pa_reg[1] <= MW'(e1_reg[2] * e2_reg[0]);
            pb_reg[1] <= MW'(e1_reg[0] * e2_reg[2]);
            pa_reg[2] <= MW'(e1_reg[0] * e2_reg[1]);
            pb_reg[2] <= MW'(e1_reg[1] * e2_reg[0]);
        end
    end

    // ---------------- stage 3: cross, sign/magnitude ----------------
    logic signed [MW:0]    cr    [3];
    logic [MW:0]           cabs  [3];
    logic [2:0][NW-1:0]    mag0_next;
    flags_t                fl0_next;
    logic [2:0][NW-1:0]    mag0_reg;
    flags_t                fl0_reg;
    logic                  v_c_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr[i]           = {pa_reg[i][MW-1], pa_reg[i]} - {pb_reg[i][MW-1], pb_reg[i]};
            cabs[i]         = cr[i][MW] ? (-cr[i]) : cr[i];
            fl0_next.neg[i] = cr[i][MW];
            mag0_next[i]    = NW'(cabs[i][MW-1:0]);
        end
        fl0_next.degen = (mag0_next[0] == '0) && (mag0_next[1] == '0) &&
                         (mag0_next[2] == '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag0_reg <= mag0_next;
            fl0_reg  <= fl0_next;
        end
    end

    // ---------------- normalizer chain ----------------
    logic               nv   [NSTG+1];
    logic [FW-1:0]      nsd  [NSTG+1];
    logic [2:0][NW-1:0] nmag [NSTG+1];

    assign nv[0]   = v_c_reg;
    assign nsd[0]  = fl0_reg;
    assign nmag[0] = mag0_reg;

    generate
        for (genvar k = 0; k < NSTG; k++) begin : g_norm
            tfn_norm_cell #(
                .W  (NW),
                .SH (1 << (NSTG - 1 - k)),
                .SW (FW)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .adv       (adv),
                .in_valid  (nv[k]),
                .in_side   (nsd[k]),
                .in_mag    (nmag[k]),
                .out_valid (nv[k+1]),
                .out_side  (nsd[k+1]),
                .out_mag   (nmag[k+1])
            );
        end
    endgenerate

    // ---------------- squares, then sum ----------------
    logic [2:0][MAG_BITS-1:0]   m_sq_reg;
    logic [2*MAG_BITS-1:0]      sq_reg [3];
    flags_t                     fl_sq_reg;
    logic                       v_q_reg;
    logic [2:0][MAG_BITS-1:0]   m_sum_reg;
    logic [SUM_BITS-1:0]        sum_reg;
    flags_t                     fl_sum_reg;
    logic                       v_s_reg;
    logic [MAG_BITS-1:0]        mtop [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mtop[i] = nmag[NSTG][i][NW-1 -: MAG_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                m_sq_reg[i] <= mtop[i];
                sq_reg[i]   <= mtop[i] * mtop[i];
            end
            fl_sq_reg  <= nsd[NSTG];
            m_sum_reg  <= m_sq_reg;
            sum_reg    <= SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) +
                          SUM_BITS'(sq_reg[2]);
            fl_sum_reg <= fl_sq_reg;
        end
    end

    // ---------------- square root chain ----------------
    logic                 sv  [ROOT_BITS+1];
    logic [SQW-1:0]       ssd [ROOT_BITS+1];
    logic [SUM_BITS-1:0]  ss  [ROOT_BITS+1];
    logic [REM_BITS-1:0]  sr  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] sq  [ROOT_BITS+1];

    assign sv[0]  = v_s_reg;
    assign ssd[0] = {fl_sum_reg, m_sum_reg};
    assign ss[0]  = sum_reg;
    assign sr[0]  = '0;
    assign sq[0]  = '0;

    generate
        for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
            tfn_sqrt_cell #(
                .SW (SQW)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .adv       (adv),
                .in_valid  (sv[k]),
                .in_side   (ssd[k]),
                .in_s      (ss[k]),
                .in_r      (sr[k]),
                .in_q      (sq[k]),
                .out_valid (sv[k+1]),
                .out_side  (ssd[k+1]),
                .out_s     (ss[k+1]),
                .out_r     (sr[k+1]),
                .out_q     (sq[k+1])
            );
        end
    endgenerate

    // ---------------- rounded dividends ----------------
    flags_t                     fl_sq_out;
    logic [2:0][MAG_BITS-1:0]   m_sq_out;
    logic [ROOT_BITS-1:0]       len;
    logic [NNW-1:0]             num [3];
    logic [ROOT_BITS-1:0]       div0_reg;
    logic [2:0][ROOT_BITS-1:0]  rem0_reg;
    logic [2:0][QW-1:0]         nq0_reg;
    flags_t                     fl_n_reg;
    logic                       v_n_reg;

    assign {fl_sq_out, m_sq_out} = ssd[ROOT_BITS];
    assign len = sq[ROOT_BITS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // m * 2^F + floor(L/2)
            num[i] = {1'b0, m_sq_out[i], {NORMAL_FRAC_BITS{1'b0}}} +
                     NNW'(len >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            div0_reg <= len;
            fl_n_reg <= fl_sq_out;
            for (int i = 0; i < 3; i++) begin
                rem0_reg[i] <= {1'b0, num[i][NNW-1:QW]};
                nq0_reg[i]  <= num[i][QW-1:0];
            end
        end
    end

    // ---------------- division chain ----------------
    logic                      dv   [QW+1];
    logic [FW-1:0]             dsd  [QW+1];
    logic [ROOT_BITS-1:0]      ddiv [QW+1];
    logic [2:0][ROOT_BITS-1:0] drem [QW+1];
    logic [2:0][QW-1:0]        dnq  [QW+1];

    assign dv[0]   = v_n_reg;
    assign dsd[0]  = fl_n_reg;
    assign ddiv[0] = div0_reg;
    assign drem[0] = rem0_reg;
    assign dnq[0]  = nq0_reg;

    generate
        for (genvar k = 0; k < QW; k++) begin : g_div
            tfn_div_cell #(
                .QW (QW),
                .SW (FW)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .adv       (adv),
                .in_valid  (dv[k]),
                .in_side   (dsd[k]),
                .in_div    (ddiv[k]),
                .in_rem    (drem[k]),
                .in_nq     (dnq[k]),
                .out_valid (dv[k+1]),
                .out_side  (dsd[k+1]),
                .out_div   (ddiv[k+1]),
                .out_rem   (drem[k+1]),
                .out_nq    (dnq[k+1])
            );
        end
    endgenerate

    assign tail_valid = dv[QW];

    // ---------------- valid bits of the inline stages ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_e_reg <= 1'b0;
            v_p_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_q_reg <= 1'b0;
            v_s_reg <= 1'b0;
            v_n_reg <= 1'b0;
        end else if (adv) begin
            v_e_reg <= s_valid;
            v_p_reg <= v_e_reg;
            v_c_reg <= v_p_reg;
            v_q_reg <= nv[NSTG];
            v_s_reg <= v_q_reg;
            v_n_reg <= sv[ROOT_BITS];
        end
    end

    // ---------------- output register, three copies ----------------
    flags_t                 fl_t;
    logic [QX-1:0]          qx  [3];
    logic [QX-1:0]          sgn [3];
    logic [NORM_WIDTH-1:0]  res [3];
    logic [NORM_WIDTH-1:0]  nx_reg, ny_reg, nz_reg;
    logic                   dg_reg;
    logic                   load;

    assign fl_t = dsd[QW];
    assign load = adv && tail_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qx[i]  = QX'(dnq[QW][i]);
            sgn[i] = fl_t.neg[i] ? (-qx[i]) : qx[i];
            res[i] = fl_t.degen ? '0 : sgn[i][NORM_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
            beat_reg     <= '0;
        end else if (load) begin
            hold_vld_reg <= 1'b1;
            beat_reg     <= '0;
        end else if (hold_vld_reg && m_ready) begin
            if (beat_reg == BEAT_LAST) begin
                hold_vld_reg <= 1'b0;
                beat_reg     <= '0;
            end else begin
                beat_reg <= beat_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            nx_reg <= res[0];
            ny_reg <= res[1];
            nz_reg <= res[2];
            dg_reg <= fl_t.degen;
        end
    end

    assign m_valid      = hold_vld_reg;
    assign m_nx         = nx_reg;
    assign m_ny         = ny_reg;
    assign m_nz         = nz_reg;
    assign m_degenerate = dg_reg;
    assign m_last       = (beat_reg == BEAT_LAST);

endmodule

>>> hdl/tfn_checker.sv
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks on the result channel of the face normal block.
// ----------------------------------------------------------------------------
`include "triangle_face_normal_defines.svh"

module tfn_checker import tfn_pkg::*; (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [NORM_WIDTH-1:0]  m_nx,
    input logic signed [NORM_WIDTH-1:0]  m_ny,
    input logic signed [NORM_WIDTH-1:0]  m_nz,
    input logic                          m_degenerate,
    input logic                          m_last
);

    // stalled request keeps its payload
    `TFN_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable({m_nx, m_ny, m_nz, m_degenerate, m_last}))

    // degenerate triangle reports a zero vector
    `TFN_ASSERT_IMPL(a_degen_zero, aclk, aresetn, m_valid && m_degenerate, (m_nx == '0) && (m_ny == '0) && (m_nz == '0))

    // copies of one normal follow without a gap
    `TFN_ASSERT_NEXT(a_copy_next, aclk, aresetn, m_valid && m_ready && !m_last, m_valid)

    // all copies carry the same normal
    `TFN_ASSERT_NEXT(a_copy_same, aclk, aresetn, m_valid && m_ready && !m_last, $stable({m_nx, m_ny, m_nz, m_degenerate}))

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);
